FILE: rtl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared constants for the 3D triangle perimeter and area pipeline.
// ----------------------------------------------------------------------------
package tpa_pkg;

	// Fixed result widths
	localparam int PER_W  = 27;
	localparam int AREA_W = 39;

	// Defaults for the top level parameters
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 12;

	// Limits of the wrapped fixed-point arithmetic
	localparam int SUM_MAX_W = 64;
	localparam int LR_MAX_W  = 64;

endpackage

FILE: rtl/tpa_in_if.sv
// ----------------------------------------------------------------------------
// tpa_in_if
// Input channel: three triangle corners, signed fixed point.
// ----------------------------------------------------------------------------
interface tpa_in_if #(
	parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready
	);
endinterface

FILE: rtl/tpa_out_if.sv
// ----------------------------------------------------------------------------
// tpa_out_if
// Result channel: perimeter, Heron area and degenerate flag.
// ----------------------------------------------------------------------------
interface tpa_out_if;
	logic                        valid;
	logic                        ready;
	logic [tpa_pkg::PER_W-1:0]   perimeter;
	logic [tpa_pkg::AREA_W-1:0]  area;
	logic                        degenerate;

	modport source (
		output valid, perimeter, area, degenerate,
		input  ready
	);
	modport sink (
		input  valid, perimeter, area, degenerate,
		output ready
	);
endinterface

FILE: rtl/tpa_isqrt.sv
// ----------------------------------------------------------------------------
// tpa_isqrt
// Pipelined floor square root, one root bit per register stage, one or more lanes.
// ----------------------------------------------------------------------------
module tpa_isqrt #(
	parameter int RAD_W = 50,
	parameter int LANES = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_v,
	input  logic [LANES-1:0][RAD_W-1:0]        rad,
	output logic                               out_v,
	output logic [LANES-1:0][RAD_W/2-1:0]      root
);
	localparam int RT = RAD_W / 2;

	logic                          v_s    [1:RT];
	logic [LANES-1:0][RAD_W-1:0]   rad_s  [1:RT-1];
	logic [LANES-1:0][RT+1:0]      rem_s  [1:RT-1];
	logic [LANES-1:0][RT-1:0]      root_s [1:RT];

	for (genvar k = 0; k < RT; k++) begin : g_step
		logic                        v_in;
		logic [LANES-1:0][RAD_W-1:0] rad_in;
		logic [LANES-1:0][RT+1:0]    rem_in;
		logic [LANES-1:0][RT-1:0]    root_in;
		logic [LANES-1:0][RT+1:0]    rem_nx;
		logic [LANES-1:0][RT-1:0]    root_nx;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = v_s[k];
			assign rad_in  = rad_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		always_comb begin
			logic [RT+1:0] sh;
			logic [RT+1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				sh    = {rem_in[l][RT-1:0], rad_in[l][RAD_W-1 -: 2]};
				trial = {root_in[l], 2'b01};
				if (sh >= trial) begin
					rem_nx[l]  = sh - trial;
					root_nx[l] = {root_in[l][RT-2:0], 1'b1};
				end else begin
					rem_nx[l]  = sh;
					root_nx[l] = {root_in[l][RT-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= root_nx;
			end
		end

		if (k < RT - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= rem_nx;
					for (int l = 0; l < LANES; l++) begin
						rad_s[k+1][l] <= {rad_in[l][RAD_W-3:0], 2'b00};
					end
				end
			end
		end
	end

	assign out_v = v_s[RT];
	assign root  = root_s[RT];

endmodule

FILE: rtl/triangle_perimeter_area_3d.sv
// ----------------------------------------------------------------------------
// triangle_perimeter_area_3d
// Perimeter and Heron area of a 3D triangle given as signed fixed-point corners.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle while the skid register is empty, and
// returns one result per triangle, in order. Two bit-per-stage square
// root pipelines compute the edge lengths first, then the root of the
// Heron product 16*A^2 = P(P-2a)(P-2b)(P-2c). Edge lengths and area are
// floored. The degenerate flag is set, with area zero, when a factor is
// zero or negative. A one-item skid register behind the last stage holds
// a result that the sink refuses; while it holds one, the whole pipeline
// stalls.
// ----------------------------------------------------------------------------
module triangle_perimeter_area_3d #(
	parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tpa_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tpa_in_if.sink    pts,
	tpa_out_if.source res
);
	localparam int D_W    = COORD_BITS + 1;
	localparam int SUM_W  = (2*COORD_BITS + 2 > tpa_pkg::SUM_MAX_W) ?
	                        tpa_pkg::SUM_MAX_W : 2*COORD_BITS + 2;
	localparam int L_W    = SUM_W / 2;
	localparam int P_W    = L_W + 2;
	localparam int LR_W   = (2*P_W > tpa_pkg::LR_MAX_W) ? tpa_pkg::LR_MAX_W : 2*P_W;
	localparam int HW     = (LR_W + 1) / 2;
	localparam int PR_W   = 2 * LR_W;
	localparam int RT2    = LR_W;
	localparam int SHIFT  = FRAC_BITS + 2;
	localparam int PER_W  = tpa_pkg::PER_W;
	localparam int AREA_W = tpa_pkg::AREA_W;

	function automatic logic [D_W-1:0] abs_diff(
		input logic [COORD_BITS-1:0] p,
		input logic [COORD_BITS-1:0] q
	);
		logic [D_W-1:0] d;
		d = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
		return d[D_W-1] ? D_W'(-d) : d;
	endfunction

	logic en;
	logic skid_v_q;
	assign en        = !skid_v_q;
	assign pts.ready = en;

	// s1: absolute coordinate differences, edges AB, BC, CA
	logic              v_s1;
	logic [D_W-1:0]    dif_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pts.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s1[0][0] <= abs_diff(pts.b_x, pts.a_x);
			dif_s1[0][1] <= abs_diff(pts.b_y, pts.a_y);
			dif_s1[0][2] <= abs_diff(pts.b_z, pts.a_z);
			dif_s1[1][0] <= abs_diff(pts.c_x, pts.b_x);
			dif_s1[1][1] <= abs_diff(pts.c_y, pts.b_y);
			dif_s1[1][2] <= abs_diff(pts.c_z, pts.b_z);
			dif_s1[2][0] <= abs_diff(pts.a_x, pts.c_x);
			dif_s1[2][1] <= abs_diff(pts.a_y, pts.c_y);
			dif_s1[2][2] <= abs_diff(pts.a_z, pts.c_z);
		end
	end

	// s2: squares
	logic             v_s2;
	logic [SUM_W-1:0] sq_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*D_W-1:0] sq;
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				for (int c = 0; c < 3; c++) begin
					sq = dif_s1[e][c] * dif_s1[e][c];
					sq_s2[e][c] <= sq[SUM_W-1:0];
				end
			end
		end
	end

	// s3: sums of squares
	logic                        v_s3;
	logic [2:0][SUM_W-1:0]       sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				sum_s3[e] <= sq_s2[e][0] + sq_s2[e][1] + sq_s2[e][2];
			end
		end
	end

	// edge lengths
	logic                  len_v;
	logic [2:0][L_W-1:0]   len;

	tpa_isqrt #(
		.RAD_W (SUM_W),
		.LANES (3)
	) u_edge_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s3),
		.rad    (sum_s3),
		.out_v  (len_v),
		.root   (len)
	);

	// s4: perimeter and Heron factors
	logic             v_s4;
	logic [P_W-1:0]   per_s4;
	logic [P_W-1:0]   ta_s4, tb_s4, tc_s4;
	logic             deg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= len_v;
		end
	end

	always_ff @(posedge clk) begin
		logic [P_W-1:0] per;
		logic [P_W:0]   t [3];
		if (en) begin
			per = P_W'(len[0]) + P_W'(len[1]) + P_W'(len[2]);
			for (int e = 0; e < 3; e++) begin
				t[e] = {1'b0, per} - {2'b00, len[e], 1'b0};
			end
			per_s4 <= per;
			ta_s4  <= t[0][P_W-1:0];
			tb_s4  <= t[1][P_W-1:0];
			tc_s4  <= t[2][P_W-1:0];
			// a factor is non-positive when negative or zero
			deg_s4 <= t[0][P_W] || t[1][P_W] || t[2][P_W] ||
			          (t[0] == '0) || (t[1] == '0) || (t[2] == '0);
		end
	end

	// s5: two half products
	logic             v_s5;
	logic [LR_W-1:0]  left_s5, right_s5;
	logic [P_W-1:0]   per_s5;
	logic             deg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*P_W-1:0] lf, rf;
		if (en) begin
			lf = per_s4 * ta_s4;
			rf = tb_s4 * tc_s4;
			left_s5  <= deg_s4 ? '0 : lf[LR_W-1:0];
			right_s5 <= deg_s4 ? '0 : rf[LR_W-1:0];
			per_s5   <= per_s4;
			deg_s5   <= deg_s4;
		end
	end

	// s6: partial products of left * right
	logic             v_s6;
	logic [2*HW-1:0]  pp_ll_s6, pp_lh_s6, pp_hl_s6, pp_hh_s6;
	logic [P_W-1:0]   per_s6;
	logic             deg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*HW-1:0] lx, rx;
		if (en) begin
			lx = (2*HW)'(left_s5);
			rx = (2*HW)'(right_s5);
			pp_ll_s6 <= lx[HW-1:0]    * rx[HW-1:0];
			pp_lh_s6 <= lx[HW-1:0]    * rx[2*HW-1:HW];
			pp_hl_s6 <= lx[2*HW-1:HW] * rx[HW-1:0];
			pp_hh_s6 <= lx[2*HW-1:HW] * rx[2*HW-1:HW];
			per_s6   <= per_s5;
			deg_s6   <= deg_s5;
		end
	end

	// s7: full Heron product
	logic             v_s7;
	logic [PR_W-1:0]  prod_s7;
	logic [P_W-1:0]   per_s7;
	logic             deg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [4*HW-1:0] acc;
		if (en) begin
			acc = (4*HW)'(pp_ll_s6)
			    + ((4*HW)'(pp_lh_s6) << HW)
			    + ((4*HW)'(pp_hl_s6) << HW)
			    + ((4*HW)'(pp_hh_s6) << (2*HW));
			prod_s7 <= acc[PR_W-1:0];
			per_s7  <= per_s6;
			deg_s7  <= deg_s6;
		end
	end

	// area root, perimeter and flag delayed alongside
	logic             root_v;
	logic [RT2-1:0]   root;

	tpa_isqrt #(
		.RAD_W (PR_W),
		.LANES (1)
	) u_area_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s7),
		.rad    (prod_s7),
		.out_v  (root_v),
		.root   (root)
	);

	logic [P_W:0] side_d [RT2+1];
	assign side_d[0] = {deg_s7, per_s7};

	for (genvar k = 0; k < RT2; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_d[k+1] <= side_d[k];
			end
		end
	end

	// s8: scaling and saturation, last stage
	logic              v_s8;
	logic [PER_W-1:0]  per_s8;
	logic [AREA_W-1:0] area_s8;
	logic              deg_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= root_v;
		end
	end

	always_ff @(posedge clk) begin
		logic [RT2+AREA_W-1:0] ax;
		logic [P_W+PER_W-1:0]  px;
		if (en) begin
			ax = (RT2+AREA_W)'(root) >> SHIFT;
			px = (P_W+PER_W)'(side_d[RT2][P_W-1:0]);
			area_s8 <= (|ax[RT2+AREA_W-1:AREA_W]) ? '1 : ax[AREA_W-1:0];
			per_s8  <= (|px[P_W+PER_W-1:PER_W]) ? '1 : px[PER_W-1:0];
			deg_s8  <= side_d[RT2][P_W];
		end
	end

	// skid register
	logic [PER_W-1:0]  per_q;
	logic [AREA_W-1:0] area_q;
	logic              deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s8 && !res.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			per_q  <= per_s8;
			area_q <= area_s8;
			deg_q  <= deg_s8;
		end
	end

	assign res.valid      = skid_v_q || v_s8;
	assign res.perimeter  = skid_v_q ? per_q  : per_s8;
	assign res.area       = skid_v_q ? area_q : area_s8;
	assign res.degenerate = skid_v_q ? deg_q  : deg_s8;

	// checks
	a_deg_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.degenerate |-> res.area == '0)
		else $error("degenerate result with nonzero area");

	a_nondeg_perimeter: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.degenerate |-> res.perimeter != '0)
		else $error("proper triangle with zero perimeter");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(v_s8 && !res.ready))
		else $error("skid filled without a stalled item");

endmodule

FILE: verif/tb_triangle_perimeter_area_3d.sv
// ----------------------------------------------------------------------------
// tb_triangle_perimeter_area_3d
// Self-checking bench for the 3D triangle perimeter and Heron area pipeline.
// ----------------------------------------------------------------------------
// A directed table of triangles (extremes, flat and coincident corners) is
// followed by random triangles of mixed scale. Each accepted item is run
// through a local predictor and the expected result is queued; results are
// compared field by field in order. Both sides idle in random bursts, the
// sink holds off long enough to fill the pipeline, and the source pauses
// once until the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_perimeter_area_3d;

	localparam int CW       = tpa_pkg::COORD_BITS_DEF;
	localparam int FW       = tpa_pkg::FRAC_BITS_DEF;
	localparam int LATENCY  = 87;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 400;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t c[9];
	} tri_t;

	typedef struct packed {
		logic [tpa_pkg::PER_W-1:0]  perimeter;
		logic [tpa_pkg::AREA_W-1:0] area;
		logic                       degenerate;
	} meas_t;

	typedef struct {
		tri_t  t;
		bit    typed;
		meas_t m;
	} row_t;

	logic clk;
	logic arst_n;

	tpa_in_if  #(.COORD_BITS(CW)) pts ();
	tpa_out_if                    res ();

	triangle_perimeter_area_3d #(.COORD_BITS(CW), .FRAC_BITS(FW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts),
		.res    (res)
	);

	meas_t expected_q[$];
	int    n_errors;
	int    idle_cycles;
	bit    sink_idle_on;
	bit    src_done;
	bit    hold_done;
	int    n_out;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor square root, bit by bit
	function automatic logic [63:0] isqrt(input logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  cand;
		logic [127:0] sq;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			sq   = 128'(cand) * 128'(cand);
			if (sq <= n)
				r = cand;
		end
		return r;
	endfunction

	function automatic logic [63:0] edge_length(input tri_t t, input int p, input int q);
		logic [127:0] s;
		longint       d;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			d = longint'(t.c[3*q+i]) - longint'(t.c[3*p+i]);
			s += 128'(d * d);
		end
		return isqrt(s);
	endfunction

	function automatic meas_t heron(input tri_t t);
		meas_t        m;
		longint       la, lb, lc, per, ta, tb, tc;
		logic [127:0] prod;
		logic [63:0]  root;
		la  = longint'(edge_length(t, 0, 1));
		lb  = longint'(edge_length(t, 1, 2));
		lc  = longint'(edge_length(t, 2, 0));
		per = la + lb + lc;
		ta  = per - 2*la;
		tb  = per - 2*lb;
		tc  = per - 2*lc;
		m.perimeter  = (per > (longint'(1) << tpa_pkg::PER_W) - 1) ? '1 :
		               per[tpa_pkg::PER_W-1:0];
		m.degenerate = (per == 0 || ta <= 0 || tb <= 0 || tc <= 0);
		m.area       = '0;
		if (!m.degenerate) begin
			prod = 128'(per) * 128'(ta) * 128'(tb) * 128'(tc);
			root = isqrt(prod) >> (FW + 2);
			m.area = (root > (64'd1 << tpa_pkg::AREA_W) - 1) ? '1 :
			         root[tpa_pkg::AREA_W-1:0];
		end
		return m;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// Result checking and watchdog
	always @(posedge clk) begin
		meas_t w;
		if (arst_n) begin
			if ((pts.valid && pts.ready) || (res.valid && res.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (res.valid && res.ready) begin
				n_out <= n_out + 1;
				if (expected_q.size() == 0) begin
					report("unexpected result, perimeter", res.perimeter, 0);
				end else begin
					w = expected_q.pop_front();
					if (res.perimeter !== w.perimeter)
						report("perimeter", res.perimeter, w.perimeter);
					if (res.area !== w.area)
						report("area", res.area, w.area);
					if (res.degenerate !== w.degenerate)
						report("degenerate", res.degenerate, w.degenerate);
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Sink side: random stall bursts, one long hold-off, none at the end
	initial begin
		int len;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && n_out >= 30) begin
				hold_done = 1'b1;
				res.ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				len = $urandom_range(1, 19);
				res.ready <= 1'b0;
				repeat (len) @(negedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	task automatic send(input tri_t t);
		pts.valid <= 1'b1;
		pts.a_x <= t.c[0]; pts.a_y <= t.c[1]; pts.a_z <= t.c[2];
		pts.b_x <= t.c[3]; pts.b_y <= t.c[4]; pts.b_z <= t.c[5];
		pts.c_x <= t.c[6]; pts.c_y <= t.c[7]; pts.c_z <= t.c[8];
		do @(posedge clk); while (!pts.ready);
		expected_q.push_back(heron(t));
		@(negedge clk);
	endtask

	task automatic src_gap(input bit allow);
		int len;
		if (allow && $urandom_range(0, 4) == 0) begin
			len = $urandom_range(1, 19);
			pts.valid <= 1'b0;
			repeat (len) @(negedge clk);
		end
	endtask

	function automatic coord_t rand_coord(input int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 8191)) - 4096);
			2: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom_range(0, 1) ? coord_t'({1'b1, {(CW-1){1'b0}}})
				: coord_t'({1'b0, {(CW-1){1'b1}}});
		endcase
	endfunction

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t ONE  = coord_t'(1 << FW);

	initial begin
		row_t table_rows[$];
		row_t r;
		tri_t t;
		int   mode;
		n_errors     = 0;
		idle_cycles  = 0;
		n_out        = 0;
		sink_idle_on = 1'b1;
		src_done     = 1'b0;
		hold_done    = 1'b0;
		pts.valid = 1'b0;
		pts.a_x = '0; pts.a_y = '0; pts.a_z = '0;
		pts.b_x = '0; pts.b_y = '0; pts.b_z = '0;
		pts.c_x = '0; pts.c_y = '0; pts.c_z = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// all corners at the origin: flat, perimeter and area zero
		r.t.c = '{default: '0}; r.typed = 1; r.m = '{0, 0, 1}; table_rows.push_back(r);
		// all corners at the same extreme point
		r.t.c = '{default: CMAX}; table_rows.push_back(r);
		r.t.c = '{default: CMIN}; table_rows.push_back(r);
		// right triangle 3-4-5 in units: P=12, area=6
		r.t.c = '{0, 0, 0, 3*ONE, 0, 0, 0, 4*ONE, 0};
		r.m = '{12 << FW, 6 << FW, 0}; table_rows.push_back(r);
		r.typed = 0;
		// collinear corners
		r.t.c = '{0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE}; table_rows.push_back(r);
		// two coincident corners
		r.t.c = '{ONE, 0, 0, ONE, 0, 0, 0, ONE, 0}; table_rows.push_back(r);
		// tiny triangles at the smallest coordinate step
		r.t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; table_rows.push_back(r);
		r.t.c = '{0, 0, 0, 1, 1, 0, 0, 0, 1}; table_rows.push_back(r);
		// maximal spans on each axis
		r.t.c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; table_rows.push_back(r);
		r.t.c = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX}; table_rows.push_back(r);
		r.t.c = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; table_rows.push_back(r);
		r.t.c = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}; table_rows.push_back(r);
		// long thin sliver
		r.t.c = '{CMIN, 0, 0, CMAX, 0, 0, 0, 1, 0}; table_rows.push_back(r);
		r.t.c = '{-1, -1, -1, 0, 0, 0, 1, -1, 0}; table_rows.push_back(r);

		foreach (table_rows[i]) begin
			send(table_rows[i].t);
			if (table_rows[i].typed && heron(table_rows[i].t) != table_rows[i].m)
				report("predictor row", i, 0);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++)
				t.c[k] = rand_coord(mode < 3 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : 3);
			// sometimes make corner C coincide with corner A
			if ($urandom_range(0, 9) == 0)
				for (int k = 0; k < 3; k++) t.c[6+k] = t.c[k];
			send(t);
			if (n == 200) begin
				// pause until everything has drained
				pts.valid <= 1'b0;
				while (expected_q.size() != 0) @(negedge clk);
			end
			if (n == 320) sink_idle_on = 1'b0;
			src_gap(n < 320);
		end
		pts.valid <= 1'b0;
		src_done = 1'b1;

		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
